>>> hdl/cfr_pkg.sv
package cfr_pkg;

  // request codes
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_FREE   = 3'd1;
  localparam logic [2:0] REQ_EVICT  = 3'd2;
  localparam logic [2:0] REQ_ACCESS = 3'd3;
  localparam logic [2:0] REQ_PIN    = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_VICTIM = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_BAD       = 2'd3;

  // victim actions
  localparam logic [1:0] ACT_DROP      = 2'd0;
  localparam logic [1:0] ACT_WRITEBACK = 2'd1;
  localparam logic [1:0] ACT_SWAP      = 2'd2;

  // one frame table entry
  typedef struct packed {
    logic valid;
    logic pinned;
    logic accessed;
    logic dirty;
    logic anon;
  } entry_t;

  // write port of the frame memory
  typedef struct packed {
    logic   we;
    entry_t data;
  } mem_wr_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC,
    S_SWEEP,
    S_DONE
  } state_t;

endpackage

>>> hdl/cfr_ifs.sv
interface cfr_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [5:0] frame_num;
  logic       is_anon;
  logic       is_write;
  logic       pin_value;

  modport source (output valid, req_type, frame_num, is_anon, is_write, pin_value,
                  input ready);
  modport sink (input valid, req_type, frame_num, is_anon, is_write, pin_value,
                output ready);
endinterface

interface cfr_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       victim_valid;
  logic [5:0] victim_frame;
  logic [1:0] victim_action;

  modport source (output valid, status, victim_valid, victim_frame, victim_action,
                  input ready);
  modport sink (input valid, status, victim_valid, victim_frame, victim_action,
                output ready);
endinterface

>>> hdl/clock_frame_replacement.sv
// Second-chance (clock) frame table. Each frame's valid, pinned, accessed,
// dirty and anonymous marks live in a synchronous memory of FRAMES entries
// with one read port and one write port, so every request is a
// read-modify-write of that memory and requests are handled one at a time.
// After reset a clearing pass writes all FRAMES entries before the first
// request is accepted. An insert, free, access or pin request goes through
// the access state and then the done state before its result loads into the
// output register; a malformed request or an evict on an empty table goes
// straight to the done state. An evict scans one frame per cycle starting
// after the hand, looking at n frames, at most 2 * FRAMES when every valid
// frame is pinned, before it enters the done state. The result register
// lets the next request be accepted while a result waits to be taken; that
// request then holds its own result until the register frees.
module clock_frame_replacement #(
  parameter int FRAMES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  cfr_req_if.sink   in_ch,
  cfr_rsp_if.source out_ch
);
  import cfr_pkg::*;

  localparam int AW = $clog2(FRAMES);

  mem_wr_t       mem_wr;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        rd_q;

  // request sequencer and hand sweep
  cfr_engine #(
    .FRAMES (FRAMES),
    .AW     (AW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_wr    (mem_wr),
    .mem_waddr (mem_waddr),
    .mem_raddr (mem_raddr),
    .rd_q      (rd_q)
  );

  // frame mark storage
  cfr_mem #(
    .FRAMES (FRAMES),
    .AW     (AW)
  ) u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .waddr (mem_waddr),
    .raddr (mem_raddr),
    .rd_q  (rd_q)
  );

endmodule

>>> hdl/cfr_mem.sv
module cfr_mem #(
  parameter int FRAMES = 64,
  parameter int AW     = 6
) (
  input  logic              clk,
  input  cfr_pkg::mem_wr_t  wr,
  input  logic [AW-1:0]     waddr,
  input  logic [AW-1:0]     raddr,
  output cfr_pkg::entry_t   rd_q
);
  import cfr_pkg::*;

  entry_t mem [FRAMES];

  // single write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_q <= mem[raddr];
  end

endmodule

>>> hdl/cfr_engine.sv
module cfr_engine #(
  parameter int FRAMES = 64,
  parameter int AW     = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  cfr_req_if.sink           in_ch,
  cfr_rsp_if.source         out_ch,
  output cfr_pkg::mem_wr_t  mem_wr,
  output logic [AW-1:0]     mem_waddr,
  output logic [AW-1:0]     mem_raddr,
  input  cfr_pkg::entry_t   rd_q
);
  import cfr_pkg::*;

  localparam int SW = $clog2(2 * FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam logic [AW-1:0] LAST_IDX  = AW'(FRAMES - 1);
  localparam logic [SW-1:0] LAST_STEP = SW'(2 * FRAMES - 1);

  state_t state_r, state_nxt;

  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] hand_r;
  logic          hand_set_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] cur_pos_r;
  logic [SW-1:0] steps_r;

  logic [2:0]    req_type_r;
  logic [AW-1:0] req_idx_r;
  logic          req_anon_r;
  logic          req_write_r;
  logic          req_pin_r;

  logic [1:0]    res_status_r;
  logic          res_vv_r;
  logic [5:0]    res_frame_r;
  logic [1:0]    res_action_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic          out_vv_r;
  logic [5:0]    out_frame_r;
  logic [1:0]    out_action_r;

  logic          accept;
  logic          in_evict;
  logic          in_bad;
  logic          in_empty;
  logic [AW-1:0] in_idx;
  logic [AW-1:0] start_pos;
  logic [AW-1:0] next_pos;
  logic          out_free;
  logic          acc_ok;
  entry_t        acc_wdata;
  logic          sweep_hit;
  logic          sweep_victim;
  logic          sweep_last;
  logic [1:0]    sweep_action;

  // request decode
  assign accept    = in_ch.valid && in_ch.ready;
  assign in_evict  = (in_ch.req_type == REQ_EVICT);
  assign in_bad    = !in_evict && ((in_ch.req_type > REQ_PIN) ||
                                   (32'(in_ch.frame_num) >= FRAMES));
  assign in_empty  = in_evict && (count_r == '0);
  assign in_idx    = AW'(in_ch.frame_num);
  assign out_free  = !out_valid_r || out_ch.ready;

  // hand arithmetic, wrapping at the table size
  assign start_pos = (!hand_set_r || hand_r == LAST_IDX) ? '0 : hand_r + 1'b1;
  assign next_pos  = (cur_pos_r == LAST_IDX) ? '0 : cur_pos_r + 1'b1;

  // read-modify decision for single-frame requests
  always_comb begin
    acc_ok    = rd_q.valid;
    acc_wdata = rd_q;
    case (req_type_r)
      REQ_INSERT: begin
        acc_ok    = !rd_q.valid;
        acc_wdata = '0;
        acc_wdata.valid = 1'b1;
        acc_wdata.anon  = req_anon_r;
      end
      REQ_FREE: begin
        acc_wdata = '0;
      end
      REQ_ACCESS: begin
        acc_wdata.accessed = 1'b1;
        acc_wdata.dirty    = rd_q.dirty | req_write_r;
      end
      default: begin
        acc_wdata.pinned = req_pin_r;
      end
    endcase
  end

  // sweep decision on the entry under the scan position
  assign sweep_hit    = rd_q.valid && !rd_q.pinned;
  assign sweep_victim = sweep_hit && !rd_q.accessed;
  assign sweep_last   = (steps_r == LAST_STEP);
  assign sweep_action = rd_q.anon ? ACT_SWAP : (rd_q.dirty ? ACT_WRITEBACK : ACT_DROP);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_addr_r == LAST_IDX) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_bad || in_empty) state_nxt = S_DONE;
          else if (in_evict)      state_nxt = S_SWEEP;
          else                    state_nxt = S_ACC;
        end
      end
      S_ACC:   state_nxt = S_DONE;
      S_SWEEP: if (sweep_victim || sweep_last) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs: handshake and memory ports
  always_comb begin
    in_ch.ready = 1'b0;
    mem_wr      = '0;
    mem_waddr   = cur_pos_r;
    mem_raddr   = cur_pos_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_wr.we = 1'b1;
        mem_waddr = clr_addr_r;
      end
      S_IDLE: begin
        in_ch.ready = 1'b1;
        mem_raddr   = in_evict ? start_pos : in_idx;
      end
      S_ACC: begin
        mem_wr.we   = acc_ok;
        mem_wr.data = acc_wdata;
        mem_waddr   = req_idx_r;
      end
      S_SWEEP: begin
        mem_raddr = next_pos;
        mem_wr.we = sweep_hit;
        if (!sweep_victim) begin
          mem_wr.data = rd_q;
          mem_wr.data.accessed = 1'b0;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      hand_r      <= '0;
      hand_set_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (state_r == S_ACC && acc_ok) begin
        if (req_type_r == REQ_INSERT)    count_r <= count_r + 1'b1;
        else if (req_type_r == REQ_FREE) count_r <= count_r - 1'b1;
      end
      if (state_r == S_SWEEP && sweep_victim) begin
        count_r    <= count_r - 1'b1;
        hand_r     <= cur_pos_r;
        hand_set_r <= 1'b1;
      end
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)             out_valid_r <= 1'b0;
    end
  end

  // request, scan and result payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      req_type_r   <= in_ch.req_type;
      req_idx_r    <= in_idx;
      req_anon_r   <= in_ch.is_anon;
      req_write_r  <= in_ch.is_write;
      req_pin_r    <= in_ch.pin_value;
      cur_pos_r    <= start_pos;
      steps_r      <= '0;
      res_status_r <= in_bad ? STAT_BAD : STAT_EMPTY;
      res_vv_r     <= 1'b0;
      res_frame_r  <= '0;
      res_action_r <= ACT_DROP;
    end
    if (state_r == S_ACC) begin
      res_status_r <= acc_ok ? STAT_OK : STAT_BAD;
    end
    if (state_r == S_SWEEP) begin
      cur_pos_r <= next_pos;
      steps_r   <= steps_r + 1'b1;
      if (sweep_victim) begin
        res_status_r <= STAT_OK;
        res_vv_r     <= 1'b1;
        res_frame_r  <= 6'(cur_pos_r);
        res_action_r <= sweep_action;
      end else if (sweep_last) begin
        res_status_r <= STAT_NO_VICTIM;
      end
    end
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_vv_r     <= res_vv_r;
      out_frame_r  <= res_frame_r;
      out_action_r <= res_action_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.victim_valid  = out_vv_r;
  assign out_ch.victim_frame  = out_frame_r;
  assign out_ch.victim_action = out_action_r;

  // frame count never exceeds the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(FRAMES))
    else $error("frame count above table size");

  // no memory write while waiting for a request or a result slot
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !mem_wr.we)
    else $error("memory write outside an active request");

  // the sweep ends by the end of its second round at the latest
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && sweep_last) |=> state_r != S_SWEEP)
    else $error("sweep ran past two rounds");

  // a chosen victim moves the hand onto it
  a_hand_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && sweep_victim) |=> hand_set_r && hand_r == $past(cur_pos_r))
    else $error("hand not moved to victim");

  // a reported victim always comes with ok status
  a_victim_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_vv_r) |-> out_status_r == STAT_OK)
    else $error("victim reported with error status");

endmodule
